FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CH8_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CH8_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CH8_ASSERT(lbl, clk, rst_n, prop)
`define CH8_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/ch8_pkg.sv
// types, constants and helpers for the chip-8 executor core
// no dependencies
package ch8_pkg;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned MAW         = $clog2(MEM_BYTES);
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SPW         = $clog2(STACK_DEPTH);

  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [4:0]  NO_KEY = 5'd16;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EXEC = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_F1,
    ST_F2,
    ST_RDY,
    ST_EXEC,
    ST_WR,
    ST_LDA,
    ST_LDB
  } state_e;

  typedef enum logic [1:0] {
    LOOP_NONE,
    LOOP_STORE,
    LOOP_BCD,
    LOOP_LOAD
  } loop_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
  } req_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic        clear_screen;
    logic        draw_request;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic [15:0] sprite_address;
    logic        sound_on;
    logic        key_wait;
  } res_t;

  function automatic logic [MAW-1:0] mem_addr(input logic [15:0] a);
    return a[MAW-1:0];
  endfunction

endpackage

FILE: rtl/core/chip8_instruction_executor_core.sv
// chip-8 executor top level: memory, register file, stack, timers, sequencer
// depends on ch8_pkg and assert_macros.svh
`include "assert_macros.svh"

// A chip-8 core with its own program memory (one write port and one registered
// read port), sixteen V registers, a return stack, index register and two
// timers. An item is taken when start is high and busy is low. Loads,
// timer ticks and unknown actions finish at the accepting edge, so their
// result appears in the next cycle and another item may follow at once.
// An execute item fetches two opcode bytes and reads Vx and Vy through one
// register read port, passing through states F1, F2, RDY and EXEC.
// Fx55 and Fx33 then write their bytes (x+1 and three) in state WR; Fx65
// loads its x+1 bytes through LDA and LDB, since each comes back through
// the memory's registered read. Each result is shown for one cycle with
// valid_o high; there is no back pressure, so the receiver must capture it then.
module chip8_instruction_executor_core
  import ch8_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  // state
  state_e state_q, state_d;
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_q;
  logic [7:0]  v_q [16];
  logic [11:0] stack_q [STACK_DEPTH];
  logic [SPW-1:0] sp_q;
  logic [11:0] pc_q;
  logic [15:0] i_q;
  logic [7:0]  dt_q, st_q;
  logic [4:0]  held_q;

  // per item work registers
  req_t        req_q;
  logic [7:0]  hi_q;
  logic [15:0] op_q;
  logic [7:0]  vx_q, vy_q;
  loop_e       loop_q;
  logic [3:0]  j_q, lim_q;
  logic [7:0]  bcd_q [3];
  res_t        res_q;
  logic        valid_q;

  // memory and register file port control
  logic           m_we;
  logic [MAW-1:0] m_wa, m_ra;
  logic [7:0]     m_wd;
  logic [3:0]     v_ra;
  logic [7:0]     v_rd;
  logic           accept;
  logic [15:0]    loop_addr;

  assign accept    = start && (state_q == ST_IDLE);
  assign loop_addr = i_q + {12'd0, j_q};
  assign v_rd      = v_q[v_ra];

  // execute decode
  logic [3:0]  e_hi, e_x, e_y, e_n;
  logic [7:0]  e_kk;
  logic [11:0] e_nnn, pc2, pc4, e_pc;
  logic        e_vwe, e_fwe, e_fwd, e_push;
  logic [7:0]  e_vwd, e_dt, e_st;
  logic [15:0] e_i;
  logic [SPW-1:0] e_sp;
  logic [4:0]  e_held;
  logic        e_clr, e_drw, e_kw;
  loop_e       e_loop;
  logic [3:0]  e_lim;
  logic [8:0]  sum9;
  logic        any_key;
  logic [3:0]  low_key;
  logic [13:0] p100;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [13:0] p10;
  logic [3:0]  tens;
  logic [7:0]  ones;
  logic [11:0] ret_pc;

  assign ret_pc = stack_q[sp_q - SPW'(1)];

  always_comb begin
    e_hi   = op_q[15:12];
    e_x    = op_q[11:8];
    e_y    = op_q[7:4];
    e_n    = op_q[3:0];
    e_kk   = op_q[7:0];
    e_nnn  = op_q[11:0];
    pc2    = pc_q + 12'd2;
    pc4    = pc_q + 12'd4;
    e_pc   = pc_q;
    e_vwe  = 1'b0;
    e_vwd  = 8'd0;
    e_fwe  = 1'b0;
    e_fwd  = 1'b0;
    e_i    = i_q;
    e_dt   = dt_q;
    e_st   = st_q;
    e_sp   = sp_q;
    e_push = 1'b0;
    e_held = held_q;
    e_clr  = 1'b0;
    e_drw  = 1'b0;
    e_kw   = 1'b0;
    e_loop = LOOP_NONE;
    e_lim  = 4'd0;
    sum9   = {1'b0, vx_q} + {1'b0, vy_q};
    // lowest held key
    any_key = |req_q.key_state;
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (req_q.key_state[k]) low_key = 4'(k);
    end
    // decimal digits by reciprocal multiplies
    p100 = {6'd0, vx_q} * 14'd41;
    hund = p100[13:12];
    rem  = 7'(vx_q - 8'(hund) * 8'd100);
    p10  = {7'd0, rem} * 14'd103;
    tens = p10[13:10];
    ones = {1'b0, rem} - 8'(tens) * 8'd10;
    unique case (e_hi)
      4'h0: begin
        if (op_q == OP_RET) begin
          e_sp = sp_q - SPW'(1);
          e_pc = ret_pc;
        end else if (op_q == OP_CLS) begin
          e_clr = 1'b1;
          e_pc  = pc2;
        end
      end
      4'h1: e_pc = e_nnn;
      4'h2: begin
        e_push = 1'b1;
        e_sp   = sp_q + SPW'(1);
        e_pc   = e_nnn;
      end
      4'h3: e_pc = (vx_q == e_kk) ? pc4 : pc2;
      4'h4: e_pc = (vx_q != e_kk) ? pc4 : pc2;
      4'h5: e_pc = (vx_q == vy_q) ? pc4 : pc2;
      4'h6: begin
        e_vwe = 1'b1;
        e_vwd = e_kk;
        e_pc  = pc2;
      end
      4'h7: begin
        e_vwe = 1'b1;
        e_vwd = vx_q + e_kk;
        e_pc  = pc2;
      end
      4'h8: begin
        e_pc = pc2;
        unique case (e_n)
          4'h0: begin e_vwe = 1'b1; e_vwd = vy_q; end
          4'h1: begin e_vwe = 1'b1; e_vwd = vx_q | vy_q; end
          4'h2: begin e_vwe = 1'b1; e_vwd = vx_q & vy_q; end
          4'h3: begin e_vwe = 1'b1; e_vwd = vx_q ^ vy_q; end
          4'h4: begin
            e_vwe = 1'b1; e_vwd = sum9[7:0];
            e_fwe = 1'b1; e_fwd = sum9[8];
          end
          4'h5: begin
            e_vwe = 1'b1; e_vwd = vx_q - vy_q;
            e_fwe = 1'b1; e_fwd = (vx_q >= vy_q);
          end
          4'h6: begin
            e_vwe = 1'b1; e_vwd = {1'b0, vx_q[7:1]};
            e_fwe = 1'b1; e_fwd = vx_q[0];
          end
          4'h7: begin
            e_vwe = 1'b1; e_vwd = vy_q - vx_q;
            e_fwe = 1'b1; e_fwd = (vx_q <= vy_q);
          end
          4'hE: begin
            e_vwe = 1'b1; e_vwd = {vx_q[6:0], 1'b0};
            e_fwe = 1'b1; e_fwd = vx_q[7];
          end
          default: ;
        endcase
      end
      4'h9: e_pc = (vx_q != vy_q) ? pc4 : pc2;
      4'hA: begin
        e_i  = {4'd0, e_nnn};
        e_pc = pc2;
      end
      // vy_q holds V0 for this opcode
      4'hB: e_pc = e_nnn + {4'd0, vy_q};
      4'hC: begin
        e_vwe = 1'b1;
        e_vwd = req_q.random_byte & e_kk;
        e_pc  = pc2;
      end
      4'hD: begin
        e_drw = 1'b1;
        e_pc  = pc2;
      end
      4'hE: begin
        if (e_y == 4'h9) begin
          e_pc = req_q.key_state[vx_q[3:0]] ? pc4 : pc2;
        end else if (e_y == 4'hA) begin
          e_pc = req_q.key_state[vx_q[3:0]] ? pc2 : pc4;
        end
      end
      4'hF: begin
        if (e_y == 4'h0 && e_n == 4'h7) begin
          e_vwe = 1'b1; e_vwd = dt_q; e_pc = pc2;
        end else if (e_y == 4'h0 && e_n == 4'hA) begin
          if (any_key) begin
            e_held = {1'b0, low_key};
            e_kw   = 1'b1;
          end else if (held_q != NO_KEY) begin
            e_vwe  = 1'b1;
            e_vwd  = {4'd0, held_q[3:0]};
            e_held = NO_KEY;
            e_pc   = pc2;
          end else begin
            e_kw = 1'b1;
          end
        end else if (e_y == 4'h1 && e_n == 4'h5) begin
          e_dt = vx_q; e_pc = pc2;
        end else if (e_y == 4'h1 && e_n == 4'h8) begin
          e_st = vx_q; e_pc = pc2;
        end else if (e_y == 4'h1 && e_n == 4'hE) begin
          e_i = i_q + {8'd0, vx_q}; e_pc = pc2;
        end else if (e_y == 4'h2) begin
          e_i = {8'd0, vx_q} * 16'd5; e_pc = pc2;
        end else if (e_y == 4'h3) begin
          e_loop = LOOP_BCD; e_lim = 4'd2; e_pc = pc2;
        end else if (e_y == 4'h5) begin
          e_loop = LOOP_STORE; e_lim = e_x; e_pc = pc2;
        end else if (e_y == 4'h6) begin
          e_loop = LOOP_LOAD; e_lim = e_x; e_pc = pc2;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && act_e'(req_i.action) == ACT_EXEC) state_d = ST_F1;
      end
      ST_F1:   state_d = ST_F2;
      ST_F2:   state_d = ST_RDY;
      ST_RDY:  state_d = ST_EXEC;
      ST_EXEC: begin
        priority case (e_loop)
          LOOP_STORE, LOOP_BCD: state_d = ST_WR;
          LOOP_LOAD:            state_d = ST_LDA;
          default:              state_d = ST_IDLE;
        endcase
      end
      ST_WR:   if (j_q == lim_q) state_d = ST_IDLE;
      ST_LDA:  state_d = ST_LDB;
      ST_LDB:  state_d = (j_q == lim_q) ? ST_IDLE : ST_LDA;
      default: state_d = ST_IDLE;
    endcase
  end

  // port control outputs
  always_comb begin
    busy   = (state_q != ST_IDLE);
    m_we   = 1'b0;
    m_wa   = mem_addr(loop_addr);
    m_wd   = (loop_q == LOOP_BCD) ? ((j_q == 4'd0) ? {6'd0, bcd_q[0][1:0]} : bcd_q[j_q[1:0]])
                                  : v_rd;
    m_ra   = mem_addr({4'd0, pc_q});
    v_ra   = j_q;
    unique case (state_q)
      ST_IDLE: begin
        m_we = accept && act_e'(req_i.action) == ACT_LOAD;
        m_wa = mem_addr({4'd0, req_i.load_address});
        m_wd = req_i.load_data;
      end
      ST_F1:   m_ra = mem_addr({4'd0, pc_q + 12'd1});
      ST_F2:   v_ra = hi_q[3:0];
      // opcode is complete in op_q here
      ST_RDY:  v_ra = (op_q[15:12] == 4'hB) ? 4'd0 : op_q[7:4];
      ST_WR:   m_we = 1'b1;
      ST_LDA:  m_ra = mem_addr(loop_addr);
      default: ;
    endcase
  end

  // program memory, one port each way, registered read
  always_ff @(posedge clk_i) begin
    if (m_we) mem[m_wa] <= m_wd;
    rdata_q <= mem[m_ra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (state_q == ST_F1) hi_q <= rdata_q;
    if (state_q == ST_F2) begin
      op_q <= {hi_q, rdata_q};
      vx_q <= v_rd;
    end
    if (state_q == ST_RDY) vy_q <= v_rd;
    if (state_q == ST_EXEC) begin
      if (e_push) stack_q[sp_q] <= pc2;
      bcd_q[0] <= {6'd0, hund};
      bcd_q[1] <= {4'd0, tens};
      bcd_q[2] <= ones;
      loop_q   <= e_loop;
      lim_q    <= e_lim;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
      sp_q    <= '0;
      pc_q    <= 12'd512;
      i_q     <= 16'd0;
      dt_q    <= 8'd0;
      st_q    <= 8'd0;
      held_q  <= NO_KEY;
      j_q     <= 4'd0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          j_q     <= 4'd0;
          valid_q <= accept && act_e'(req_i.action) != ACT_EXEC;
          if (accept && act_e'(req_i.action) != ACT_EXEC) begin
            // loads, ticks and unknown actions finish right here
            if (act_e'(req_i.action) == ACT_TICK) begin
              if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
              if (st_q != 8'd0) st_q <= st_q - 8'd1;
            end
            res_q.program_counter <= pc_q;
            res_q.clear_screen    <= 1'b0;
            res_q.draw_request    <= 1'b0;
            res_q.draw_x          <= 8'd0;
            res_q.draw_y          <= 8'd0;
            res_q.draw_rows       <= 4'd0;
            res_q.sprite_address  <= 16'd0;
            res_q.key_wait        <= 1'b0;
            res_q.sound_on <= (act_e'(req_i.action) == ACT_TICK) ? (st_q > 8'd1)
                                                                  : (st_q != 8'd0);
          end
        end
        ST_EXEC: begin
          // the result write is skipped when x is VF and the flag is written, so the flag wins
          if (e_vwe && !(e_fwe && e_x == 4'hF)) v_q[e_x] <= e_vwd;
          if (e_fwe) v_q[15] <= {7'd0, e_fwd};
          pc_q   <= e_pc;
          i_q    <= e_i;
          dt_q   <= e_dt;
          st_q   <= e_st;
          sp_q   <= e_sp;
          held_q <= e_held;
          valid_q <= (e_loop == LOOP_NONE);
          res_q.program_counter <= e_pc;
          res_q.clear_screen    <= e_clr;
          res_q.draw_request    <= e_drw;
          res_q.draw_x          <= e_drw ? vx_q : 8'd0;
          res_q.draw_y          <= e_drw ? vy_q : 8'd0;
          res_q.draw_rows       <= e_drw ? e_n : 4'd0;
          res_q.sprite_address  <= e_drw ? i_q : 16'd0;
          res_q.sound_on        <= (e_st != 8'd0);
          res_q.key_wait        <= e_kw;
        end
        ST_WR: begin
          valid_q <= (j_q == lim_q);
          if (j_q == lim_q) begin
            if (loop_q == LOOP_STORE) i_q <= loop_addr + 16'd1;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        ST_LDB: begin
          v_q[j_q] <= rdata_q;
          valid_q  <= (j_q == lim_q);
          if (j_q == lim_q) begin
            i_q <= loop_addr + 16'd1;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        default: valid_q <= 1'b0;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // an accepted execute item keeps the block busy on the next cycle
  `CH8_ASSERT(a_exec_busy, clk_i, rst_ni,
    (start && !busy && req_i.action == ACT_EXEC) |=> busy)
  // a result never asks for both clear and draw
  `CH8_ASSERT(a_one_request, clk_i, rst_ni,
    valid_o |-> !(res_o.clear_screen && res_o.draw_request))
  // a waiting key read leaves the program counter where it was
  `CH8_ASSERT(a_wait_holds_pc, clk_i, rst_ni,
    (valid_o && res_o.key_wait) |-> (res_o.program_counter == pc_q))

endmodule
